[design/pufb_pkg.sv]
// ----------------------------------------------------------------------------
// pufb_pkg
// types and codes shared by the persistent union-find bottleneck unit
// ----------------------------------------------------------------------------
`default_nettype none

package pufb_pkg;

  // request codes
  localparam logic REQ_JOIN  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_JW1,
    S_JW2,
    S_MID,
    S_WRD,
    S_WDAT
  } state_t;

  // which root walk is running
  typedef enum logic [2:0] {
    PH_JA,
    PH_JB,
    PH_QA,
    PH_QB,
    PH_SA,
    PH_SB
  } phase_t;

endpackage

`default_nettype wire

[design/persistent_union_find_bottleneck_unit.sv]
// ----------------------------------------------------------------------------
// persistent_union_find_bottleneck_unit
// partially persistent union-find with time-stamped links and bottleneck
// queries by binary search over merge times
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  request   start, busy, req_type, node_a, node_b,
//            edge_weight                                      in (busy out)
//  result    done, merged, connected, bottleneck_weight       out
//
//  one request at a time; each parent step of a root walk is a node memory
//  read (S_RD) followed by the check (S_CHK)
//  join: a walk from each node, then the link write and the root update;
//  a query adds one pair of walks per binary-search round over the merge
//  times (about log2 of the merge count rounds), plus the weight read
//  after reset the node memory is swept once, one entry a
//  cycle, with busy high
//  the receiver cannot stall: done is high for exactly one cycle per request
`default_nettype none

module persistent_union_find_bottleneck_unit #(
  parameter int NODES       = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [9:0]  node_a,
  input  wire logic [9:0]  node_b,
  input  wire logic [31:0] edge_weight,
  output logic             done,
  output logic             merged,
  output logic             connected,
  output logic [31:0]      bottleneck_weight
);
  import pufb_pkg::*;

  localparam int NODE_BITS = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int TIME_BITS = $clog2(NODES + 2);
  localparam int ENT_W     = 1 + 2 * TIME_BITS + NODE_BITS;

  localparam logic [TIME_BITS-1:0] T_ALL = '1;
  localparam logic [TIME_BITS-1:0] T_ONE = TIME_BITS'(1);
  localparam logic [TIME_BITS-1:0] T_NODES = TIME_BITS'(NODES);

  // node memory: {is_root, set_size, link_time, parent_index}
  logic [ENT_W-1:0]       nmem [NODES];
  logic [WEIGHT_BITS-1:0] wmem [NODES];

  state_t state, state_next;
  phase_t phase;

  logic [NODE_BITS-1:0]   a, b, cur, ra, big, child;
  logic [WEIGHT_BITS-1:0] w;
  logic [TIME_BITS-1:0]   limit, counter, lo, hi, mid, ans;
  logic [TIME_BITS-1:0]   ra_size, small_size, sum_size;
  logic [NODE_BITS-1:0]   clr_idx;

  logic [ENT_W-1:0]       ent_q;
  logic [WEIGHT_BITS-1:0] wq;

  logic                   ent_root;
  logic [TIME_BITS-1:0]   ent_size, ent_time;
  logic [NODE_BITS-1:0]   ent_par;
  logic                   at_root;
  logic                   in_range, accept;

  logic                   nm_we;
  logic [NODE_BITS-1:0]   nm_waddr;
  logic [ENT_W-1:0]       nm_wdata;
  logic                   wm_we;
  logic [NODE_BITS-1:0]   wm_raddr;
  logic [TIME_BITS-1:0]   ans_cl;

  // entry fields
  assign ent_root = ent_q[ENT_W-1];
  assign ent_size = ent_q[ENT_W-2 -: TIME_BITS];
  assign ent_time = ent_q[NODE_BITS +: TIME_BITS];
  assign ent_par  = ent_q[NODE_BITS-1:0];
  assign at_root  = ent_root || (ent_time > limit);

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(node_a) < 32'(NODES)) && (32'(node_b) < 32'(NODES));

  // clamp of the earliest merge time
  assign ans_cl   = (ans > counter - T_ONE) ? counter - T_ONE : ans;
  assign wm_raddr = NODE_BITS'(ans_cl - T_ONE);

  // memories
  always_ff @(posedge clk) begin
    if (nm_we) begin
      nmem[nm_waddr] <= nm_wdata;
    end
    ent_q <= nmem[cur];
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[NODE_BITS'(counter - T_ONE)] <= w;
    end
    wq <= wmem[wm_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (32'(clr_idx) == 32'(NODES - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept && in_range) state_next = S_RD;
      S_RD:    state_next = S_CHK;
      S_CHK: begin
        if (!at_root) begin
          state_next = S_RD;
        end else begin
          unique case (phase)
            PH_JA, PH_QA, PH_SA: state_next = S_RD;
            PH_JB: begin
              if (ra == cur || counter - T_ONE >= T_NODES) state_next = S_IDLE;
              else state_next = S_JW1;
            end
            PH_QB: begin
              if (ra != cur || counter <= T_ONE) state_next = S_IDLE;
              else state_next = S_MID;
            end
            PH_SB:   state_next = S_MID;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_JW1:   state_next = S_JW2;
      S_JW2:   state_next = S_IDLE;
      S_MID:   state_next = (lo > hi) ? S_WRD : S_RD;
      S_WRD:   state_next = S_WDAT;
      S_WDAT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory write controls
  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = clr_idx;
    nm_wdata = {1'b1, T_ONE, {TIME_BITS{1'b0}}, {NODE_BITS{1'b0}}};
    wm_we    = 1'b0;
    unique case (state)
      S_CLEAR: nm_we = 1'b1;
      S_JW1: begin
        nm_we    = 1'b1;
        nm_waddr = child;
        nm_wdata = {1'b0, small_size, counter, big};
        wm_we    = 1'b1;
      end
      S_JW2: begin
        nm_we    = 1'b1;
        nm_waddr = big;
        nm_wdata = {1'b1, sum_size, {TIME_BITS{1'b0}}, {NODE_BITS{1'b0}}};
      end
      default: nm_we = 1'b0;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      counter <= T_ONE;
      done    <= 1'b0;
      phase   <= PH_JA;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (accept) begin
            a     <= NODE_BITS'(node_a);
            b     <= NODE_BITS'(node_b);
            cur   <= NODE_BITS'(node_a);
            w     <= WEIGHT_BITS'(edge_weight);
            limit <= T_ALL;
            phase <= (req_type == REQ_QUERY) ? PH_QA : PH_JA;
            if (!in_range) begin
              done              <= 1'b1;
              merged            <= 1'b0;
              connected         <= 1'b0;
              bottleneck_weight <= '0;
            end
          end
        end
        S_CHK: begin
          if (!at_root) begin
            cur <= ent_par;
          end else begin
            unique case (phase)
              PH_JA, PH_QA, PH_SA: begin
                ra      <= cur;
                ra_size <= ent_size;
                cur     <= b;
                phase   <= (phase == PH_JA) ? PH_JB : (phase == PH_QA) ? PH_QB : PH_SB;
              end
              PH_JB: begin
                if (ra == cur || counter - T_ONE >= T_NODES) begin
                  done              <= 1'b1;
                  merged            <= 1'b0;
                  connected         <= 1'b0;
                  bottleneck_weight <= '0;
                end else begin
                  if (ent_size > ra_size) begin
                    big        <= cur;
                    child      <= ra;
                    small_size <= ra_size;
                  end else begin
                    big        <= ra;
                    child      <= cur;
                    small_size <= ent_size;
                  end
                  sum_size <= ra_size + ent_size;
                end
              end
              PH_QB: begin
                if (ra != cur || counter <= T_ONE) begin
                  done              <= 1'b1;
                  merged            <= 1'b0;
                  connected         <= (ra == cur);
                  bottleneck_weight <= '0;
                end else begin
                  lo  <= T_ONE;
                  hi  <= counter;
                  ans <= T_ONE;
                end
              end
              PH_SB: begin
                if (ra == cur) begin
                  ans <= mid;
                  hi  <= mid - T_ONE;
                end else begin
                  lo <= mid + T_ONE;
                end
              end
              default: phase <= phase;
            endcase
          end
        end
        S_JW2: begin
          counter           <= counter + T_ONE;
          done              <= 1'b1;
          merged            <= 1'b1;
          connected         <= 1'b0;
          bottleneck_weight <= '0;
        end
        S_MID: begin
          if (lo <= hi) begin
            mid   <= lo + ((hi - lo) >> 1);
            limit <= lo + ((hi - lo) >> 1);
            cur   <= a;
            phase <= PH_SA;
          end
        end
        S_WDAT: begin
          done              <= 1'b1;
          merged            <= 1'b0;
          connected         <= 1'b1;
          bottleneck_weight <= 32'(wq);
        end
        default: done <= 1'b0;
      endcase
    end
  end

  // checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("result without request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(merged && connected)) else $error("join and query flags both set");

  a_weight_needs_link: assert property (@(posedge clk) disable iff (rst)
    (done && !connected) |-> bottleneck_weight == '0) else $error("stray weight");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |-> counter <= T_NODES) else $error("merge counter overflow");

endmodule

`default_nettype wire

[tb/sv/persistent_union_find_bottleneck_unit_tb.sv]
// ----------------------------------------------------------------------------
// persistent_union_find_bottleneck_unit_tb
// drives join and bottleneck-query requests into the union-find unit, keeps
// its own time-stamped forest alongside and checks every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module persistent_union_find_bottleneck_unit_tb;
  import pufb_pkg::*;

  localparam int NUM_NODES = 1024;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [9:0]  node_a;
  logic [9:0]  node_b;
  logic [31:0] edge_weight;
  logic        done;
  logic        merged;
  logic        connected;
  logic [31:0] bottleneck_weight;

  typedef struct packed {
    logic        merged;
    logic        connected;
    logic [31:0] weight;
  } outcome_t;

  // shadow forest
  logic [9:0]  forest_parent [NUM_NODES];
  logic        forest_root   [NUM_NODES];
  logic [10:0] forest_size   [NUM_NODES];
  logic [10:0] forest_stamp  [NUM_NODES];
  logic [31:0] weight_log    [NUM_NODES];
  logic [10:0] next_merge;

  outcome_t pending_outcomes[$];
  int       fail_count;
  int       request_count;
  int       result_count;
  int       query_hits;
  logic     rx_stall;

  persistent_union_find_bottleneck_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
    .done(done), .merged(merged), .connected(connected),
    .bottleneck_weight(bottleneck_weight)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #400ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [9:0] root_by(input logic [9:0] n, input logic [10:0] lim);
    logic [9:0] u;
    u = n;
    for (int s = 0; s < NUM_NODES; s++) begin
      if (forest_root[u] || forest_stamp[u] > lim) break;
      u = forest_parent[u];
    end
    return u;
  endfunction

  // predicted outcome of one request, updating the shadow forest
  function automatic outcome_t apply_request(input logic rq, input logic [9:0] a,
                                             input logic [9:0] b, input logic [31:0] w);
    outcome_t   o;
    logic [9:0] ra, rb, t;
    logic [10:0] lo, hi, mid, ans;
    o = '0;
    if (rq == REQ_JOIN) begin
      ra = root_by(a, 11'h7ff);
      rb = root_by(b, 11'h7ff);
      if (ra != rb && next_merge - 11'd1 < NUM_NODES) begin
        if (forest_size[rb] > forest_size[ra]) begin
          t = ra; ra = rb; rb = t;
        end
        forest_parent[rb] = ra;
        forest_root[rb] = 1'b0;
        forest_stamp[rb] = next_merge;
        weight_log[next_merge - 11'd1] = w;
        next_merge = next_merge + 11'd1;
        forest_size[ra] = forest_size[ra] + forest_size[rb];
        o.merged = 1'b1;
      end
    end else if (root_by(a, 11'h7ff) == root_by(b, 11'h7ff)) begin
      o.connected = 1'b1;
      if (next_merge > 11'd1) begin
        lo = 11'd1; hi = next_merge; ans = 11'd1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (root_by(a, mid) == root_by(b, mid)) begin
            ans = mid; hi = mid - 11'd1;
          end else begin
            lo = mid + 11'd1;
          end
        end
        if (ans > next_merge - 11'd1) ans = next_merge - 11'd1;
        o.weight = weight_log[ans - 11'd1];
      end
    end
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && done) begin
      result_count++;
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (merged !== exp_o.merged) begin
          $error("merged: expected %0d actual %0d", exp_o.merged, merged);
          fail_count++;
        end
        if (connected !== exp_o.connected) begin
          $error("connected: expected %0d actual %0d", exp_o.connected, connected);
          fail_count++;
        end
        if (bottleneck_weight !== exp_o.weight) begin
          $error("bottleneck_weight: expected %0h actual %0h", exp_o.weight,
                 bottleneck_weight);
          fail_count++;
        end
        if (exp_o.connected) query_hits++;
      end
    end
  end

  // receiver pattern: cannot hold off, toggled only for variety
  always @(posedge clk) rx_stall <= ($urandom_range(0, 3) == 0);

  // send one request; wait until busy is low, then drop start and return
  task automatic send_request(input logic rq, input logic [9:0] a, input logic [9:0] b,
                              input logic [31:0] w);
    start <= 1'b1;
    req_type <= rq;
    node_a <= a;
    node_b <= b;
    edge_weight <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.insert(pending_outcomes.size(), apply_request(rq, a, b, w));
    request_count++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // extremes and special cases
  task automatic test_directed();
    send_request(REQ_QUERY, 10'd0, 10'd0, 32'hffffffff);
    send_request(REQ_QUERY, 10'd1023, 10'd0, 32'd0);
    send_request(REQ_JOIN, 10'd0, 10'd1023, 32'hffffffff);
    send_request(REQ_JOIN, 10'd1023, 10'd0, 32'd7);
    send_request(REQ_QUERY, 10'd0, 10'd1023, 32'd0);
    send_request(REQ_QUERY, 10'd5, 10'd5, 32'd0);
    send_request(REQ_QUERY, 10'd5, 10'd6, 32'd0);
    send_request(REQ_JOIN, 10'd5, 10'd6, 32'h80000000);
    send_request(REQ_JOIN, 10'd6, 10'd1023, 32'h0000ffff);
    send_request(REQ_QUERY, 10'd5, 10'd0, 32'hffffffff);
    send_request(REQ_JOIN, 10'd5, 10'd5, 32'd3);
    send_request(REQ_JOIN, 10'd682, 10'd341, 32'h55555555);
    send_request(REQ_QUERY, 10'd341, 10'd682, 32'd0);
    // hold off until every result is back
    wait_drained();
    send_request(REQ_QUERY, 10'd1023, 10'd1023, 32'd0);
  endtask

  // random weighted-forest scenarios, bursts of clustered nodes
  task automatic test_random(input int n);
    int         span;
    logic [31:0] w;
    w = 32'hffffffff;
    span = 16;
    for (int k = 0; k < n; k++) begin
      logic       rq;
      logic [9:0] a, b;
      if (k % 200 == 0) span = (k % 400 == 0) ? 1024 : 24;
      rq = ($urandom_range(0, 2) == 0) ? REQ_JOIN : REQ_QUERY;
      a = 10'($urandom_range(0, span - 1));
      b = 10'($urandom_range(0, span - 1));
      if ($urandom_range(0, 9) == 0) b = a;
      if ($urandom_range(0, 9) == 0) w = $urandom();
      else w = w - 32'($urandom_range(0, 1000));
      send_request(rq, a, b, w);
      if (!rx_stall) random_gap();
    end
  endtask

  // long chain of joins into one set, then queries across it
  task automatic test_chain();
    for (int k = 0; k < 60; k++) send_request(REQ_JOIN, 10'(100 + k), 10'(101 + k),
                                               32'(1000 - k));
    for (int k = 0; k < 40; k++)
      send_request(REQ_QUERY, 10'($urandom_range(90, 170)), 10'($urandom_range(90, 170)),
                   $urandom());
  endtask

  initial begin
    fail_count = 0;
    request_count = 0;
    result_count = 0;
    query_hits = 0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_JOIN;
    node_a = '0;
    node_b = '0;
    edge_weight = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      forest_parent[i] = '0;
      forest_root[i] = 1'b1;
      forest_size[i] = 11'd1;
      forest_stamp[i] = '0;
      weight_log[i] = '0;
    end
    next_merge = 11'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_chain();
    test_random(1100);
    wait_drained();
    repeat (300) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      fail_count++;
    end
    $display("covered %0d requests, %0d results, %0d connected queries, %0d merges",
             request_count, result_count, query_hits, next_merge - 1);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pufb_pkg.sv
design/persistent_union_find_bottleneck_unit.sv
tb/sv/persistent_union_find_bottleneck_unit_tb.sv
